>>> rtl/wma_pkg.sv
package wma_pkg;

    // Sample and result width, Q16.16
    localparam int SAMPLE_BITS = 32;
    // Default window depth; fill_count and window_size are 9 bits, so depths above 511 lie
    // outside what the ports can express
    localparam int WINDOW_MAX_DEF = 256;
    // Width of fill count, window size and divisor
    localparam int CNT_W = 9;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_W-1:0]              t_count;

endpackage

>>> rtl/wma_if.sv
interface wma_in_if;
    import wma_pkg::*;

    logic    valid;
    logic    ready;
    logic    req_type;
    t_sample sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface wma_out_if;
    import wma_pkg::*;

    logic    valid;
    logic    ready;
    t_sample average;
    t_count  fill_count;

    modport source (output valid, output average, output fill_count, input ready);
    modport sink   (input valid, input average, input fill_count, output ready);
endinterface

interface wma_cfg_if;
    import wma_pkg::*;

    logic   valid;
    logic   ready;
    t_count window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

>>> rtl/windowed_moving_average.sv
// An add while the window fills goes from acceptance through S_DIV and S_DIVW to S_HOLD;
// an add into a full window passes S_RD and S_SUB first; a clear goes straight to S_HOLD.
// Throughput: one item at a time; the input is ready again once the result is registered,
// so with the output ready the divide sets the pace of an add, with the shared restoring
// divider at one quotient bit per cycle; a stalled output holds the input off.
// Reset (synchronous, active low): window size 1, window empty, ring store not cleared.
module windowed_moving_average #(
    parameter int WINDOW_MAX = wma_pkg::WINDOW_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wma_cfg_if.sink    i_cfg,
    wma_in_if.sink     i_in,
    wma_out_if.source  o_out
);
    import wma_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    logic [2:0]              r_state, n_state;
    t_count                  r_wsize, n_wsize;
    t_count                  r_held, n_held;
    logic [IDX_W-1:0]        r_head, n_head;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    t_sample                 r_sample, n_sample;
    t_sample                 r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_sample                 r_out_avg, n_out_avg;
    t_count                  r_out_fill, n_out_fill;

    logic                    in_fire;
    logic                    cfg_fire;
    logic                    out_load;
    t_count                  cfg_w;
    t_count                  head_inc;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] old_ext;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    t_sample                 ram_wdata;
    t_sample                 ram_rdata;

    logic                    div_start;
    logic                    div_done;
    t_sample                 div_q;

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign in_fire     = i_in.valid && i_in.ready;

    assign sample_ext = SUM_W'(i_in.sample);
    assign old_ext    = SUM_W'(ram_rdata);
    assign head_inc   = CNT_W'(r_head) + CNT_W'(1);

    always_comb begin
        cfg_w = i_cfg.window_size;
        if (cfg_w == '0) begin
            cfg_w = CNT_W'(1);
        end
        if (32'(i_cfg.window_size) > 32'(WINDOW_MAX)) begin
            cfg_w = CNT_W'(WINDOW_MAX);
        end
    end

    assign out_load = (r_state == S_HOLD) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state   = r_state;
        n_wsize   = r_wsize;
        n_held    = r_held;
        n_head    = r_head;
        n_sum     = r_sum;
        n_sample  = r_sample;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_wdata = r_sample;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    n_wsize = cfg_w;
                    n_held  = '0;
                    n_head  = '0;
                    n_sum   = '0;
                end else if (in_fire) begin
                    if (i_in.req_type == REQ_CLEAR) begin
                        n_held  = '0;
                        n_head  = '0;
                        n_sum   = '0;
                        n_res   = '0;
                        n_state = S_HOLD;
                    end else begin
                        n_sample = i_in.sample;
                        n_sum    = r_sum + sample_ext;
                        if (r_held < r_wsize) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_held[IDX_W-1:0];
                            ram_wdata = i_in.sample;
                            n_head    = r_held[IDX_W-1:0];
                            n_held    = r_held + CNT_W'(1);
                            n_state   = S_DIV;
                        end else begin
                            // window full: advance to the oldest entry and fetch it
                            if (head_inc >= r_wsize) begin
                                n_head = '0;
                            end else begin
                                n_head = head_inc[IDX_W-1:0];
                            end
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                // drop the oldest sample and overwrite its slot
                n_sum   = r_sum - old_ext;
                ram_we  = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    n_res   = div_q;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_fill  = r_out_fill;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_avg   = r_res;
            n_out_fill  = r_held;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wsize     <= CNT_W'(1);
            r_held      <= '0;
            r_head      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wsize     <= n_wsize;
            r_held      <= n_held;
            r_head      <= n_head;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_sample   <= n_sample;
        r_res      <= n_res;
        r_out_avg  <= n_out_avg;
        r_out_fill <= n_out_fill;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.average    = r_out_avg;
    assign o_out.fill_count = r_out_fill;

    wma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    wma_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_held),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

endmodule

>>> rtl/wma_ram.sv
module wma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/wma_div.sv
module wma_div #(
    parameter int SUM_W = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_W-1:0]       i_dividend,
    input  wma_pkg::t_count               i_divisor,
    output logic                          o_done,
    output wma_pkg::t_sample              o_quotient
);
    import wma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_ABS  = 2'd1;
    localparam logic [1:0] D_STEP = 2'd2;
    localparam logic [1:0] D_NEG  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    t_count            r_div, n_div;
    logic              r_neg, n_neg;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_done, n_done;
    t_sample           r_q, n_q;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_diff;
    logic [SUM_W-1:0]  quo_neg;

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign quo_neg  = ~r_quo + SUM_W'(1);

    always_comb begin
        n_state = r_state;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        n_step  = r_step;
        n_done  = 1'b0;
        n_q     = r_q;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_quo   = i_dividend;
                    n_neg   = i_dividend[SUM_W-1];
                    n_div   = i_divisor;
                    n_state = D_ABS;
                end
            end
            D_ABS: begin
                if (r_neg) begin
                    n_quo = quo_neg;
                end
                n_rem   = '0;
                n_step  = '0;
                n_state = D_STEP;
            end
            D_STEP: begin
                // restoring step: one quotient bit per cycle
                if (!rem_diff[CNT_W]) begin
                    n_rem = rem_diff[CNT_W-1:0];
                end else begin
                    n_rem = rem_sh[CNT_W-1:0];
                end
                n_quo  = {r_quo[SUM_W-2:0], ~rem_diff[CNT_W]};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = D_NEG;
                end
            end
            D_NEG: begin
                n_q     = r_neg ? quo_neg[SAMPLE_BITS-1:0] : r_quo[SAMPLE_BITS-1:0];
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_neg  <= n_neg;
        r_step <= n_step;
        r_q    <= n_q;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
